>>> src/ladder_lowpass_filter_macros.svh
// ----------------------------------------------------------------------------
// Ladder lowpass filter assertion macros
// Helpers for the concurrent checks of the filter controller.
// ----------------------------------------------------------------------------
`ifndef LADDER_LOWPASS_FILTER_MACROS_SVH
`define LADDER_LOWPASS_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/llf_pkg.sv
// ----------------------------------------------------------------------------
// Ladder lowpass filter package
// Types, fixed-point constants and helpers shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package llf_pkg;

    localparam int GUARD_BITS = 8;
    localparam int STATE_W    = 32;
    localparam int BETA_W     = 25;
    localparam int NUM_BETA   = 4;
    localparam int BIDX_W     = 2;
    localparam int MUL_A_W    = 41;
    localparam int MUL_B_W    = 26;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int WIDE_W     = PROD_W + 1;

    localparam logic [BETA_W-1:0]        COEF_ONE = 25'd16777216;
    localparam logic signed [MUL_B_W-1:0] K_ONE   = 26'sd1048576;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 68'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN = -68'sd2147483648;

    typedef enum logic [2:0] {
        CFG_ALPHA    = 3'd0,
        CFG_SCALE    = 3'd1,
        CFG_FEEDBACK = 3'd2,
        CFG_POLES    = 3'd3,
        CFG_BYPASS   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0]        alpha;
        logic [24:0]        scale;
        logic signed [23:0] k;
        logic [2:0]         poles;
        logic               bypass;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_PASS,
        OP_BETA_M, OP_BETA_W, OP_SIG_M, OP_SIG_W,
        OP_DRV_M, OP_DRV_W, OP_FB_M, OP_FB_W,
        OP_U_M, OP_U_W, OP_ST_M, OP_ST_W,
        OP_FIN, OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_CLEAR, S_PASS,
        S_BETA_M, S_BETA_W, S_SIG_M, S_SIG_W,
        S_DRV_M, S_DRV_W, S_FB_M, S_FB_W,
        S_U_M, S_U_W, S_ST_M, S_ST_W,
        S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [BIDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic              bypass;
        logic              out_free;
        logic [BIDX_W-1:0] last_idx;
    } t_stat;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > S32_MAX) begin
            return 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            return 32'sh80000000;
        end
        return v[STATE_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/ladder_lowpass_filter.sv
// ----------------------------------------------------------------------------
// Ladder lowpass filter
// Two-channel four-pole ladder lowpass with one shared multiplier.
// ----------------------------------------------------------------------------
//  Channel   Signals                                      Direction
//  input     i_valid/o_ready, i_kind, i_channel, i_sample_in   in
//  output    o_valid/i_ready, o_sample_out                      out
//  config    i_cfg_we, i_cfg_index, i_cfg_data                  in
//
//  A filtered sample runs BETA, SIG (per active pole), DRV, FB, U, ST (per
//  active pole), FIN and OUT, every product through the single registered
//  multiplier; a new beat can be accepted in the same cycle its result shows.
//  A clear or bypassed beat goes through CLEAR or PASS to OUT. Reset restores
//  the register defaults and zeroes all pole states at once. A stalled result
//  holds in the output register; the next beat is accepted meanwhile and waits
//  at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module ladder_lowpass_filter
    import llf_pkg::*;
#(
    parameter int CHANNELS    = 2,
    parameter int MAX_POLES   = 4,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_kind,
    input  wire logic                          i_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [24:0]                   i_cfg_data
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha  <= 24'd8388608;
            r_cfg.scale  <= 25'd16777216;
            r_cfg.k      <= '0;
            r_cfg.poles  <= 3'd4;
            r_cfg.bypass <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ALPHA:    r_cfg.alpha  <= i_cfg_data[23:0];
                CFG_SCALE:    r_cfg.scale  <= i_cfg_data;
                CFG_FEEDBACK: r_cfg.k      <= i_cfg_data[23:0];
                CFG_POLES:    r_cfg.poles  <= i_cfg_data[2:0];
                CFG_BYPASS:   r_cfg.bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    llf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    llf_datapath #(
        .CHANNELS    (CHANNELS),
        .MAX_POLES   (MAX_POLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .i_kind       (i_kind),
        .i_channel    (i_channel),
        .i_sample_in  (i_sample_in),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out)
    );

endmodule

`default_nettype wire

>>> src/llf_ctrl.sv
// ----------------------------------------------------------------------------
// Ladder lowpass filter controller
// Sequences the shared multiplier through coefficient, feedback and stage steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ladder_lowpass_filter_macros.svh"

module llf_ctrl
    import llf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic [BIDX_W-1:0] r_idx, n_idx;
    logic accept;

    assign o_ready = (r_state == S_IDLE) && i_rst_n;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE:     if (accept) n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (i_stat.kind) begin
                    n_state = S_CLEAR;
                end else if (i_stat.bypass) begin
                    n_state = S_PASS;
                end else begin
                    n_state = S_BETA_M;
                    n_idx   = BIDX_W'(NUM_BETA - 2);
                end
            end
            S_CLEAR:    n_state = S_OUT;
            S_PASS:     n_state = S_OUT;
            S_BETA_M:   n_state = S_BETA_W;
            S_BETA_W: begin
                if (r_idx == '0) begin
                    n_state = S_SIG_M;
                end else begin
                    n_state = S_BETA_M;
                    n_idx   = r_idx - 1'b1;
                end
            end
            S_SIG_M:    n_state = S_SIG_W;
            S_SIG_W: begin
                if (r_idx == i_stat.last_idx) begin
                    n_state = S_DRV_M;
                end else begin
                    n_state = S_SIG_M;
                    n_idx   = r_idx + 1'b1;
                end
            end
            S_DRV_M:    n_state = S_DRV_W;
            S_DRV_W:    n_state = S_FB_M;
            S_FB_M:     n_state = S_FB_W;
            S_FB_W:     n_state = S_U_M;
            S_U_M:      n_state = S_U_W;
            S_U_W: begin
                n_state = S_ST_M;
                n_idx   = '0;
            end
            S_ST_M:     n_state = S_ST_W;
            S_ST_W: begin
                if (r_idx == i_stat.last_idx) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ST_M;
                    n_idx   = r_idx + 1'b1;
                end
            end
            S_FIN:      n_state = S_OUT;
            S_OUT:      if (i_stat.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.idx = r_idx;
        case (r_state)
            S_IDLE:   o_cmd.op = accept ? OP_LOAD : OP_NONE;
            S_CLEAR:  o_cmd.op = OP_CLEAR;
            S_PASS:   o_cmd.op = OP_PASS;
            S_BETA_M: o_cmd.op = OP_BETA_M;
            S_BETA_W: o_cmd.op = OP_BETA_W;
            S_SIG_M:  o_cmd.op = OP_SIG_M;
            S_SIG_W:  o_cmd.op = OP_SIG_W;
            S_DRV_M:  o_cmd.op = OP_DRV_M;
            S_DRV_W:  o_cmd.op = OP_DRV_W;
            S_FB_M:   o_cmd.op = OP_FB_M;
            S_FB_W:   o_cmd.op = OP_FB_W;
            S_U_M:    o_cmd.op = OP_U_M;
            S_U_W:    o_cmd.op = OP_U_W;
            S_ST_M:   o_cmd.op = OP_ST_M;
            S_ST_W:   o_cmd.op = OP_ST_W;
            S_FIN:    o_cmd.op = OP_FIN;
            S_OUT:    o_cmd.op = i_stat.out_free ? OP_OUT : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    `LLF_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, accept, r_state == S_DISPATCH, "accepted beat did not dispatch")
    `LLF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT) && !i_stat.out_free, r_state == S_OUT, "result dropped while output stalled")
    `LLF_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, (r_state == S_SIG_W) || (r_state == S_ST_W), r_idx <= i_stat.last_idx, "pole index past last active pole")

endmodule

`default_nettype wire

>>> src/llf_datapath.sv
// ----------------------------------------------------------------------------
// Ladder lowpass filter datapath
// Shared multiplier, pole state registers, accumulators and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module llf_datapath
    import llf_pkg::*;
#(
    parameter int CHANNELS    = 2,
    parameter int MAX_POLES   = 4,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cfg                          i_cfg,
    input  wire t_cmd                          i_cmd,
    input  wire logic                          i_kind,
    input  wire logic                          i_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output t_stat                              o_stat,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW   = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;
    localparam logic signed [32:0] OUT_MAX = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] OUT_MIN = -(33'sd1 <<< (SAMPLE_BITS - 1));

    logic                          r_kind, r_byp;
    logic [CH_W-1:0]               r_ch;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [BETA_W-1:0]             r_beta [NUM_BETA];
    logic signed [WIDE_W-1:0]      r_sig_acc;
    logic signed [35:0]            r_sigma;
    logic signed [PROD_W-1:0]      r_prod, r_drv;
    logic signed [STATE_W-1:0]     r_acc, r_u;
    logic signed [STATE_W-1:0]     r_pole [CHANNELS][MAX_POLES];
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                          r_out_valid;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [PW-1:0]             pidx;
    logic signed [STATE_W-1:0] cur_s;
    logic [2:0]                npoles;
    logic signed [WIDE_W-1:0]  prod_w, prod_rnd24, sh24, fb_diff, v_w, y_w, s_w;
    logic signed [STATE_W-1:0] y_sat, s_sat;
    logic signed [32:0]        out_rnd;
    logic [WIDE_W-1:0]         beta_rnd;

    assign pidx   = i_cmd.idx[PW-1:0];
    assign cur_s  = r_pole[r_ch][pidx];
    assign prod_w = WIDE_W'(r_prod);

    // Zero poles count as one, anything above the cascade length as the full cascade.
    always_comb begin
        if (i_cfg.poles == 3'd0) begin
            npoles = 3'd1;
        end else if (i_cfg.poles > 3'(MAX_POLES)) begin
            npoles = 3'(MAX_POLES);
        end else begin
            npoles = i_cfg.poles;
        end
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.bypass   = r_byp;
    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_stat.last_idx = BIDX_W'(npoles - 3'd1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_BETA_M: begin
                mul_a = MUL_A_W'({1'b0, i_cfg.alpha});
                mul_b = MUL_B_W'({1'b0, r_beta[i_cmd.idx + 1'b1]});
            end
            OP_SIG_M: begin
                mul_a = MUL_A_W'(cur_s);
                mul_b = MUL_B_W'({1'b0, r_beta[i_cmd.idx]});
            end
            OP_DRV_M: begin
                mul_a = MUL_A_W'($signed({r_x, {GUARD_BITS{1'b0}}}));
                mul_b = MUL_B_W'(i_cfg.k) + K_ONE;
            end
            OP_FB_M: begin
                mul_a = MUL_A_W'(r_sigma);
                mul_b = MUL_B_W'(i_cfg.k);
            end
            OP_U_M: begin
                mul_a = MUL_A_W'(r_acc);
                mul_b = MUL_B_W'({1'b0, i_cfg.scale});
            end
            OP_ST_M: begin
                mul_a = MUL_A_W'(33'(r_u) - 33'(cur_s));
                mul_b = MUL_B_W'({1'b0, i_cfg.alpha});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        prod_rnd24 = prod_w + WIDE_W'(64'sd8388608);
        sh24       = prod_rnd24 >>> 24;
        beta_rnd   = prod_rnd24 >> 24;
        fb_diff    = (WIDE_W'(r_drv) - prod_w + WIDE_W'(64'sd524288)) >>> 20;
        v_w        = sh24;
        y_w        = WIDE_W'(cur_s) + v_w;
        y_sat      = sat32(y_w);
        s_w        = WIDE_W'(y_sat) + v_w;
        s_sat      = sat32(s_w);
        out_rnd    = (33'(r_u) + 33'sd128) >>> GUARD_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_LOAD: begin
                r_kind    <= i_kind;
                r_ch      <= (CHANNELS > 1) ? CH_W'(i_channel) : '0;
                r_x       <= i_sample_in;
                r_byp     <= i_cfg.bypass;
                r_beta[NUM_BETA-1] <= COEF_ONE - BETA_W'(i_cfg.alpha);
                r_sig_acc <= '0;
            end
            OP_CLEAR: begin
                r_res <= '0;
                for (int c = 0; c < CHANNELS; c++) begin
                    for (int p = 0; p < MAX_POLES; p++) begin
                        r_pole[c][p] <= '0;
                    end
                end
            end
            OP_PASS:   r_res <= r_x;
            OP_BETA_W: r_beta[i_cmd.idx] <= beta_rnd[BETA_W-1:0];
            OP_SIG_W:  r_sig_acc <= r_sig_acc + prod_w;
            OP_DRV_W: begin
                r_drv   <= r_prod;
                r_sigma <= 36'((r_sig_acc + WIDE_W'(64'sd8388608)) >>> 24);
            end
            OP_FB_W:   r_acc <= sat32(fb_diff);
            OP_U_W:    r_u <= sat32(sh24);
            OP_ST_W: begin
                r_pole[r_ch][pidx] <= s_sat;
                r_u <= y_sat;
            end
            OP_FIN: begin
                if (out_rnd > OUT_MAX) begin
                    r_res <= OUT_MAX[SAMPLE_BITS-1:0];
                end else if (out_rnd < OUT_MIN) begin
                    r_res <= OUT_MIN[SAMPLE_BITS-1:0];
                end else begin
                    r_res <= out_rnd[SAMPLE_BITS-1:0];
                end
            end
            OP_OUT:    o_sample_out <= r_res;
            default: ;
        endcase
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int p = 0; p < MAX_POLES; p++) begin
                    r_pole[c][p] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire
